[rtl/tlbpt_pkg.sv]
package tlbpt_pkg;

  localparam int ADDR_W          = 16;
  localparam int PAGE_W          = 8;
  localparam int OFFSET_W        = 8;
  localparam int FRAME_W         = 8;
  localparam int COUNT_W         = 32;
  localparam int PAGES           = 256;
  localparam int NFF_W           = 9;
  localparam int TLB_ENTRIES_DEF = 16;

  typedef struct packed {
    logic capture;      // latch the incoming address
    logic commit_hit;   // retire a TLB hit into the output register
    logic commit_miss;  // retire a miss: table update, TLB refill, output
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;          // TLB match on the held page
    logic out_free;     // output register can take a result this cycle
  } ctrl_stat_t;

endpackage

[rtl/tlbpt_ram.sv]
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/tlbpt_ctrl.sv]
module tlbpt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tlbpt_pkg::ctrl_stat_t  stat,
  output tlbpt_pkg::ctrl_cmd_t   cmd
);
  import tlbpt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_TABLE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        // page table read is issued here regardless; used only on a miss
        if (stat.hit) begin
          if (stat.out_free) begin
            cmd.commit_hit = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          state_next = S_TABLE;
        end
      end
      S_TABLE: begin
        if (stat.out_free) begin
          cmd.commit_miss = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/tlbpt_datapath.sv]
module tlbpt_datapath #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tlbpt_pkg::ctrl_cmd_t          cmd,
  output tlbpt_pkg::ctrl_stat_t         stat,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [tlbpt_pkg::COUNT_W-1:0] tlb_hit_total,
  output logic [tlbpt_pkg::COUNT_W-1:0] fault_total
);
  import tlbpt_pkg::*;

  localparam int PTR_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(TLB_ENTRIES - 1);

  logic [ADDR_W-1:0]   addr;
  logic [PAGE_W-1:0]   page;
  logic [OFFSET_W-1:0] offset;

  logic [PAGE_W-1:0]      tlb_tags    [TLB_ENTRIES];
  logic [FRAME_W-1:0]     slot_frames [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [PTR_W-1:0]       fifo_pointer;

  logic [PAGES-1:0]   table_valid;
  logic [NFF_W-1:0]   next_free_frame;
  logic [COUNT_W-1:0] hit_count;
  logic [COUNT_W-1:0] fault_count;

  logic               match;
  logic [FRAME_W-1:0] match_frame;
  logic [FRAME_W-1:0] table_rdata;
  logic               mapped;
  logic [FRAME_W-1:0] miss_frame;
  logic               table_we;

  assign page   = addr[ADDR_W-1 -: PAGE_W];
  assign offset = addr[OFFSET_W-1:0];

  // parallel tag compare; highest matching slot wins
  always_comb begin
    match       = 1'b0;
    match_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_valid[i] && (tlb_tags[i] == page)) begin
        match       = 1'b1;
        match_frame = slot_frames[i];
      end
    end
  end

  assign stat.hit      = match;
  assign stat.out_free = !out_valid || out_ready;

  assign mapped     = table_valid[page];
  assign miss_frame = mapped ? table_rdata : next_free_frame[FRAME_W-1:0];
  assign table_we   = cmd.commit_miss && !mapped;

  // read address is the held page, so the registered data is ready by S_TABLE
  tlbpt_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (PAGES)
  ) u_table (
    .clk   (clk),
    .we    (table_we),
    .addr  (page),
    .wdata (miss_frame),
    .rdata (table_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      addr <= logical_address;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_miss) begin
      tlb_tags[fifo_pointer]    <= page;
      slot_frames[fifo_pointer] <= miss_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid       <= '0;
      fifo_pointer    <= '0;
      table_valid     <= '0;
      next_free_frame <= '0;
      hit_count       <= '0;
      fault_count     <= '0;
    end else begin
      if (cmd.commit_hit && (hit_count != '1)) begin
        hit_count <= hit_count + 1'b1;
      end
      if (cmd.commit_miss) begin
        tlb_valid[fifo_pointer] <= 1'b1;
        fifo_pointer <= (fifo_pointer == PTR_LAST) ? '0 : fifo_pointer + 1'b1;
        if (!mapped) begin
          table_valid[page] <= 1'b1;
          if (!next_free_frame[NFF_W-1]) begin
            next_free_frame <= next_free_frame + 1'b1;
          end
          if (fault_count != '1) begin
            fault_count <= fault_count + 1'b1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit_hit || cmd.commit_miss) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_hit) begin
      physical_address <= {match_frame, offset};
      tlb_hit          <= 1'b1;
      page_fault       <= 1'b0;
    end else if (cmd.commit_miss) begin
      physical_address <= {miss_frame, offset};
      tlb_hit          <= 1'b0;
      page_fault       <= !mapped;
    end
  end

  // totals only move on a commit, which needs the output slot free
  assign tlb_hit_total = hit_count;
  assign fault_total   = fault_count;

endmodule

[rtl/tlb_page_table_translator_core.sv]
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   logical_address
// out      output     out_valid / out_ready physical_address, tlb_hit, page_fault,
//                                           tlb_hit_total, fault_total
//
// A TLB hit reaches the output register from S_LOOK after the input transfer, a miss
// from S_TABLE: the extra state is the registered page table read before its update.
// Each address also passes through the idle state that takes the next address.
// One address is in translation at a time; a new one is taken once the previous
// result sits in the output register, even while it waits there.
// Synchronous reset clears TLB valid bits, page table valid bits, the FIFO
// pointer, the free frame counter and both totals; no clearing pass is needed.
// A stalled output holds the block in its final state until the slot frees.
module tlb_page_table_translator_core #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tlbpt_pkg::ADDR_W-1:0]  logical_address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tlbpt_pkg::ADDR_W-1:0]  physical_address,
  output logic                          tlb_hit,
  output logic                          page_fault,
  output logic [tlbpt_pkg::COUNT_W-1:0] tlb_hit_total,
  output logic [tlbpt_pkg::COUNT_W-1:0] fault_total
);
  import tlbpt_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  tlbpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .tlb_hit_total    (tlb_hit_total),
    .fault_total      (fault_total)
  );

endmodule

[dv/tb_tlb_page_table_translator_core.sv]
`timescale 1ns / 100ps

module tb_tlb_page_table_translator_core;
  import tlbpt_pkg::*;

  localparam int TLB_N        = TLB_ENTRIES_DEF;
  localparam int RANDOM_ITEMS = 1425;
  localparam int SWEEP_AT     = 600;

  typedef struct packed {
    logic [ADDR_W-1:0]  phys;
    logic               hit;
    logic               fault;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
  } xlat_t;

  typedef enum logic [1:0] {RX_OPEN, RX_BUSY, RX_SLOW, RX_BEAT} rx_mode_t;

  class xlat_scoreboard;
    logic [PAGE_W-1:0]  tlb_tag[TLB_N];
    logic [FRAME_W-1:0] slot_frame[TLB_N];
    bit                 tlb_valid[TLB_N];
    logic [FRAME_W-1:0] page_frame[PAGES];
    bit                 page_mapped[PAGES];
    logic [NFF_W-1:0]   free_frame;
    int                 fill_slot;
    logic [COUNT_W-1:0] hits;
    logic [COUNT_W-1:0] faults;
    xlat_t              expected_xlat[$];
    int                 errors;
    int                 checked;

    function new();
      foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
      foreach (page_mapped[i]) page_mapped[i] = 1'b0;
      free_frame = '0;
      fill_slot  = 0;
      hits       = '0;
      faults     = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function logic [COUNT_W-1:0] sat_bump(logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // translate one address against the shadow TLB / page table
    function void note_address(logic [ADDR_W-1:0] addr);
      logic [PAGE_W-1:0]  page;
      logic [FRAME_W-1:0] frame;
      xlat_t              want;
      page       = addr[ADDR_W-1:OFFSET_W];
      frame      = '0;
      want       = '0;
      for (int i = 0; i < TLB_N; i++) begin
        if (tlb_valid[i] && tlb_tag[i] == page) begin
          frame    = slot_frame[i];
          want.hit = 1'b1;
        end
      end
      if (want.hit) begin
        hits = sat_bump(hits);
      end else begin
        if (!page_mapped[page]) begin
          page_frame[page]  = free_frame[FRAME_W-1:0];
          page_mapped[page] = 1'b1;
          if (free_frame < PAGES) free_frame = free_frame + 1'b1;
          faults     = sat_bump(faults);
          want.fault = 1'b1;
        end
        frame                 = page_frame[page];
        tlb_tag[fill_slot]    = page;
        slot_frame[fill_slot] = frame;
        tlb_valid[fill_slot]  = 1'b1;
        fill_slot             = (fill_slot + 1) % TLB_N;
      end
      want.phys   = {frame, addr[OFFSET_W-1:0]};
      want.hits   = hits;
      want.faults = faults;
      expected_xlat.push_back(want);
    endfunction

    function void report(string field, logic [COUNT_W-1:0] exp_v, logic [COUNT_W-1:0] act_v);
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    endfunction

    function void check_translation(xlat_t got);
      xlat_t want;
      if (expected_xlat.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: out transfer with nothing pending, actual phys %h",
                   $time, got.phys);
        return;
      end
      want = expected_xlat.pop_front();
      checked++;
      if (got.phys !== want.phys)     report("physical_address", want.phys, got.phys);
      if (got.hit !== want.hit)       report("tlb_hit", want.hit, got.hit);
      if (got.fault !== want.fault)   report("page_fault", want.fault, got.fault);
      if (got.hits !== want.hits)     report("tlb_hit_total", want.hits, got.hits);
      if (got.faults !== want.faults) report("fault_total", want.faults, got.faults);
    endfunction

    function int pending();
      return expected_xlat.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ADDR_W-1:0]  logical_address = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ADDR_W-1:0]  physical_address;
  logic               tlb_hit;
  logic               page_fault;
  logic [COUNT_W-1:0] tlb_hit_total;
  logic [COUNT_W-1:0] fault_total;

  rx_mode_t           rx_mode = RX_OPEN;
  int unsigned        rx_cycle = 0;
  logic [PAGE_W-1:0]  hot_pages[8];
  logic [PAGE_W-1:0]  warm_pages[24];

  xlat_scoreboard sb = new();

  tlb_page_table_translator_core #(.TLB_ENTRIES(TLB_N)) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .logical_address  (logical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .physical_address (physical_address),
    .tlb_hit          (tlb_hit),
    .page_fault       (page_fault),
    .tlb_hit_total    (tlb_hit_total),
    .fault_total      (fault_total)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_address(logical_address);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_translation({physical_address, tlb_hit, page_fault, tlb_hit_total, fault_total});
  end

  // receiver backpressure: a randomly drawn mode sets out_ready
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_BUSY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_SLOW: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_cycle % 5) < 3;
    endcase
  end

  // mostly local references so the TLB sees hits and FIFO churn
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       r;
    logic [PAGE_W-1:0] page;
    r = $urandom_range(0, 9);
    if (r < 5)      page = hot_pages[$urandom_range(0, 7)];
    else if (r < 8) page = warm_pages[$urandom_range(0, 23)];
    else            page = PAGE_W'($urandom_range(0, PAGES - 1));
    return {page, OFFSET_W'($urandom_range(0, 255))};
  endfunction

  task automatic send_address(input logic [ADDR_W-1:0] addr);
    in_valid        <= 1'b1;
    logical_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] stim[$];
    logic [PAGE_W-1:0] sweep[PAGES];
    logic [PAGE_W-1:0] tmp;
    int                burst;
    int                gap;
    int                j;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, hit on same page, then 16 new pages to wrap the FIFO
    stim = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00};
    for (int p = 1; p <= 16; p++) stim.push_back({p[7:0], 8'(p * 17)});
    // evicted pages come back from the table without a fault
    stim.push_back(16'h0080);
    stim.push_back(16'hFF7F);
    stim.push_back(16'h0ABC);
    stim.push_back(16'h5555);
    stim.push_back(16'hAAAA);

    for (int k = 0; k < RANDOM_ITEMS - PAGES; k++) begin
      if (k % 100 == 0) begin
        foreach (hot_pages[i]) hot_pages[i] = PAGE_W'($urandom_range(0, PAGES - 1));
        foreach (warm_pages[i]) warm_pages[i] = PAGE_W'($urandom_range(0, PAGES - 1));
      end
      // touch every page once in shuffled order: frames run out after this
      if (k == SWEEP_AT) begin
        foreach (sweep[i]) sweep[i] = PAGE_W'(i);
        for (int i = PAGES - 1; i > 0; i--) begin
          j        = $urandom_range(0, i);
          tmp      = sweep[i];
          sweep[i] = sweep[j];
          sweep[j] = tmp;
        end
        foreach (sweep[i]) stim.push_back({sweep[i], OFFSET_W'($urandom_range(0, 255))});
      end
      stim.push_back(pick_address());
    end

    burst = $urandom_range(1, 40);
    foreach (stim[i]) begin
      send_address(stim[i]);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("translated %0d addresses: %0d TLB hits, %0d page faults",
             sb.checked, sb.hits, sb.faults);
    $display("all %0d pages mapped by the end, free frame counter at %0d",
             PAGES, sb.free_frame);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout at %0t", $time);
    $display("status: fail");
    $finish;
  end

endmodule
